// ===== rtl/alc_pkg.sv =====
// Shared types, constants and helpers for the array list engine.
// Depends on nothing; imported by alc_cell, array_list_engine and the testbench.
`default_nettype none

package alc_pkg;

	// List geometry.
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Fixed widths of the stream fields.
	localparam int KIND_W   = 3;
	localparam int POS_W    = 5;
	localparam int VALUE_W  = 32;
	localparam int OIDX_W   = 4;
	localparam int OCNT_W   = 5;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 16;

	// Width that holds both a position and a count for compares.
	localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Request kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_SEARCH       = 3'd0,
		KIND_INSERT       = 3'd1,
		KIND_APPEND       = 3'd2,
		KIND_DELETE_AT    = 3'd3,
		KIND_DELETE_VALUE = 3'd4
	} kind_t;

	// Per-cell update command for one cycle.
	typedef struct packed {
		logic load;
		logic take_left;
		logic take_right;
	} cell_ctrl_t;

	// Sign-extend the 32-bit input word, then keep DATA_WIDTH bits.
	function automatic word_t to_word(input logic [VALUE_W-1:0] v);
		logic [2*VALUE_W-1:0] ext;
		ext = {{VALUE_W{v[VALUE_W-1]}}, v};
		return word_t'(ext);
	endfunction

	// Lowest set bit of a match vector; zero when none is set.
	function automatic logic [IDX_W-1:0] first_index(input logic [CAPACITY-1:0] m);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/alc_cell.sv =====
// One storage cell of the list: holds an entry, compares it with a probe
// word and loads from its neighbors or the insert word. Uses alc_pkg.
`default_nettype none

module alc_cell (
	input  wire                 clk,
	input  wire                 en,
	input  alc_pkg::cell_ctrl_t ctrl,
	input  alc_pkg::word_t      left_word,
	input  alc_pkg::word_t      right_word,
	input  alc_pkg::word_t      ins_word,
	input  alc_pkg::word_t      cmp_word,
	output alc_pkg::word_t      entry,
	output logic                eq
);
	import alc_pkg::*;

	word_t entry_q;

	// Entry register: an insert loads or shifts up, a delete shifts down.
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctrl.load) begin
				entry_q <= ins_word;
			end else if (ctrl.take_left) begin
				entry_q <= left_word;
			end else if (ctrl.take_right) begin
				entry_q <= right_word;
			end
		end
	end

	// Parallel compare against the probe word.
	assign eq    = (entry_q == cmp_word);
	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== rtl/array_list_engine.sv =====
// Flow: a request beat is taken into the stage-one registers, which also capture
// the cells' match vector; stage two then updates the cells and loads the result
// register once that register is free or being emptied. The cells compare first
// and shift after, and a new request is taken only once the previous one has
// updated the cells.
// Reset: the entry count and handshake state clear; entries stay undefined
// until written, and no entry at or beyond the count can match a probe.
`default_nettype none

module array_list_engine (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// Fields from bit 0: position[4:0], value[36:5], zero fill.
	input  wire [alc_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// Fields from bit 0: kind[2:0].
	input  wire [alc_pkg::KIND_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// Fields from bit 0: ok[0], found[1], found_index[5:2], count[10:6], zero fill.
	output logic [alc_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import alc_pkg::*;

	// Input field unpacking.
	logic [POS_W-1:0]   in_pos;
	logic [VALUE_W-1:0] in_value;
	logic               in_beat;

	assign in_pos   = s_axis_tdata[POS_W-1:0];
	assign in_value = s_axis_tdata[POS_W+VALUE_W-1:POS_W];

	// Control and stage registers.
	logic                busy_q;
	logic [CNT_W-1:0]    count_q;
	logic [KIND_W-1:0]   kind_s1;
	logic [POS_W-1:0]    pos_s1;
	word_t               word_s1;
	logic [CAPACITY-1:0] match_s1;
	logic                out_valid_q;
	logic                ok_q;
	logic                found_q;
	logic [OIDX_W-1:0]   idx_q;
	logic [OCNT_W-1:0]   ocount_q;

	// Cell array signals.
	word_t               entry   [CAPACITY];
	logic [CAPACITY-1:0] eq;
	cell_ctrl_t          ctrl    [CAPACITY];
	word_t               in_word;
	word_t               probe;
	logic [CW-1:0]       cnt_ext;

	assign in_word = to_word(in_value);
	assign probe   = busy_q ? word_s1 : in_word;
	assign cnt_ext = CW'(count_q);

	// Request is taken only when no earlier request is still updating the cells.
	assign s_axis_tready = !busy_q;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// Stage two fires when the result register is free or being emptied.
	logic fire;
	assign fire = busy_q && (!out_valid_q || m_axis_tready);

	// Decision logic for the request in stage two.
	logic             found;
	logic [IDX_W-1:0] idx;
	logic             ok;
	logic             ins_ok;
	logic             del_ok;
	logic [CW-1:0]    ins_pos;
	logic [CW-1:0]    del_pos;
	logic [CW-1:0]    pos_ext;
	logic [CNT_W-1:0] count_next;

	assign pos_ext = CW'(pos_s1);

	always_comb begin
		found   = 1'b0;
		idx     = '0;
		ins_ok  = 1'b0;
		del_ok  = 1'b0;
		ins_pos = pos_ext;
		del_pos = pos_ext;
		case (kind_t'(kind_s1))
			KIND_SEARCH: begin
				found = |match_s1;
				idx   = first_index(match_s1);
			end
			KIND_INSERT: begin
				ins_ok = (cnt_ext < CW'(CAPACITY)) && (pos_ext <= cnt_ext);
			end
			KIND_APPEND: begin
				ins_pos = cnt_ext;
				ins_ok  = (cnt_ext < CW'(CAPACITY));
			end
			KIND_DELETE_AT: begin
				del_ok = (pos_ext < cnt_ext);
			end
			KIND_DELETE_VALUE: begin
				found   = |match_s1;
				idx     = first_index(match_s1);
				del_pos = CW'(idx);
				del_ok  = found;
			end
			default: begin
				found = 1'b0;
			end
		endcase
		ok = found || ins_ok || del_ok;
		if (ins_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
	end

	// Row of cells, each linked to its neighbors; an end cell uses its own entry on its open side.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_w;
		word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = entry[i];
		end else begin : g_left
			assign left_w = entry[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = entry[i];
		end else begin : g_right
			assign right_w = entry[i+1];
		end

		assign ctrl[i].load       = ins_ok && (CW'(i) == ins_pos);
		assign ctrl[i].take_left  = ins_ok && (CW'(i) > ins_pos);
		assign ctrl[i].take_right = del_ok && (CW'(i) >= del_pos);

		alc_cell u_cell (
			.clk        (clk),
			.en         (fire),
			.ctrl       (ctrl[i]),
			.left_word  (left_w),
			.right_word (right_w),
			.ins_word   (word_s1),
			.cmp_word   (probe),
			.entry      (entry[i]),
			.eq         (eq[i])
		);
	end

	// Valid mask: only entries below the count may match.
	logic [CAPACITY-1:0] match_now;
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_now[i] = eq[i] && (CW'(i) < cnt_ext);
		end
	end

	// Stage one payload: the request and the registered match vector.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_s1  <= s_axis_tuser;
			pos_s1   <= in_pos;
			word_s1  <= in_word;
			match_s1 <= match_now;
		end
	end

	// Control state: busy flag, entry count, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_beat) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			ok_q     <= ok;
			found_q  <= found;
			idx_q    <= OIDX_W'(idx);
			ocount_q <= OCNT_W'(count_next);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_DATA_W'({ocount_q, idx_q, found_q, ok_q});

`ifndef SYNTH
	// The count never grows past the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// A found match always makes the request succeed.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> ok_q)
		else $error("match found but request failed");

	// Without a match the reported index is zero.
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> (idx_q == '0))
		else $error("nonzero index without a match");

	// The count moves by at most one per request.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1))
			|| (count_q == $past(count_q) - CNT_W'(1)))
		else $error("count changed by more than one");

	// The count only changes on a request that stage two completes.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q))
		else $error("count changed without a request");
`endif

endmodule

`default_nettype wire

// ===== verif/array_list_engine_tb.sv =====
// Self-checking testbench for array_list_engine: directed and random list requests
// on the stream ports, checked against a queue-based model of the list.
// Depends on alc_pkg and array_list_engine from the rtl folder.
`default_nettype none

module array_list_engine_tb;

	import alc_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 9;
	localparam int ITEMS_PER_PHASE = 430;
	localparam int HOLD_CYCLES    = 80;
	localparam int HOLD_AT_ITEM   = 150;
	localparam int DRAIN_CYCLES   = 16;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int MAX_REPORTS    = 10;

	// Kind codes that the block does not define; they must leave the list alone.
	localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

	// One result beat, packed in the same bit order as m_axis_tdata.
	typedef struct packed {
		logic [OCNT_W-1:0] entry_count;
		logic [OIDX_W-1:0] found_index;
		logic              found;
		logic              ok;
	} list_result_t;

	// Mirror of the list contents plus the queue of results still owed by the block.
	class list_scoreboard;
		word_t        entries[$];
		list_result_t owed_results[$];
		int unsigned  mismatches;
		int unsigned  results_seen;

		// Index of the first entry equal to w, or -1.
		function int first_hit(word_t w);
			foreach (entries[k]) begin
				if (entries[k] == w) begin
					return k;
				end
			end
			return -1;
		endfunction

		function logic place(int unsigned p, word_t w);
			if (entries.size() >= CAPACITY || p > entries.size()) begin
				return 1'b0;
			end
			entries.insert(p, w);
			return 1'b1;
		endfunction

		function logic remove(int unsigned p);
			if (p >= entries.size()) begin
				return 1'b0;
			end
			entries.delete(p);
			return 1'b1;
		endfunction

		function word_t random_entry();
			return entries[$urandom_range(entries.size() - 1)];
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		// Apply one accepted request to the mirror and queue the result it owes.
		function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
				logic [VALUE_W-1:0] value);
			word_t        w;
			list_result_t r;
			int           hit;
			w   = word_t'($signed(value));
			r   = '0;
			hit = first_hit(w);
			case (kind)
				KIND_SEARCH: begin
					r.found = (hit >= 0);
					r.ok    = r.found;
					if (hit >= 0) begin
						r.found_index = OIDX_W'(hit);
					end
				end
				KIND_INSERT: begin
					r.ok = place(pos, w);
				end
				KIND_APPEND: begin
					r.ok = place(entries.size(), w);
				end
				KIND_DELETE_AT: begin
					r.ok = remove(pos);
				end
				KIND_DELETE_VALUE: begin
					if (hit >= 0) begin
						r.found       = 1'b1;
						r.found_index = OIDX_W'(hit);
						r.ok          = remove(hit);
					end
				end
				default: begin
				end
			endcase
			r.entry_count = OCNT_W'(entries.size());
			owed_results.push_back(r);
		endfunction

		// Compare one result beat against the oldest owed result.
		function void check_result(logic [M_DATA_W-1:0] data);
			list_result_t got;
			list_result_t want;
			got = list_result_t'(data[$bits(list_result_t)-1:0]);
			results_seen++;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("result beat %0d arrived with no request outstanding: data=%h",
						results_seen, data);
				end
				return;
			end
			want = owed_results.pop_front();
			if (got.ok !== want.ok || got.found !== want.found ||
					got.found_index !== want.found_index ||
					got.entry_count !== want.entry_count) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display({"result beat %0d: expected ok=%0b found=%0b index=%0d count=%0d,",
						" got ok=%0b found=%0b index=%0d count=%0d"},
						results_seen, want.ok, want.found, want.found_index, want.entry_count,
						got.ok, got.found, got.found_index, got.entry_count);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_DATA_W-1:0]  s_axis_tdata;
	logic [KIND_W-1:0]    s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_DATA_W-1:0]  m_axis_tdata;

	list_scoreboard list_model = new;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;
	bit filling        = 1'b1;

	logic [VALUE_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_00A5};

	array_list_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watch both ports at the rising edge; results first, then the new request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				list_model.check_result(m_axis_tdata);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				list_model.note_request(s_axis_tuser, s_axis_tdata[POS_W-1:0],
					s_axis_tdata[POS_W+VALUE_W-1:POS_W]);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one request beat, with random idle cycles first; returns at the
	// falling edge after the beat was taken.
	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] value);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_DATA_W'({value, pos});
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random request shaped by the current trend: fill the list up or drain it.
	task automatic send_random_request();
		logic [KIND_W-1:0]  kind;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
		int unsigned        held;
		int unsigned        r;
		held = list_model.entries.size();
		r    = $urandom_range(99);
		if (r < 15) begin
			kind = KIND_SEARCH;
		end else if (r < (filling ? 45 : 25)) begin
			kind = KIND_INSERT;
		end else if (r < (filling ? 75 : 35)) begin
			kind = KIND_APPEND;
		end else if (r < (filling ? 85 : 65)) begin
			kind = KIND_DELETE_AT;
		end else if (r < 96) begin
			kind = KIND_DELETE_VALUE;
		end else begin
			kind = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
		end

		// Mostly legal positions, sometimes anything the field can carry.
		pos = POS_W'($urandom_range(31));
		if (kind == KIND_INSERT && $urandom_range(9) < 8) begin
			pos = POS_W'($urandom_range(held));
		end else if (kind == KIND_DELETE_AT && held > 0 && $urandom_range(9) < 8) begin
			pos = POS_W'($urandom_range(held - 1));
		end

		// Values from a small pool or from the list itself make matches common.
		r = $urandom_range(99);
		if (r < 35) begin
			value = value_pool[$urandom_range(7)];
		end else if (r < 70 && held > 0) begin
			value = list_model.random_entry();
		end else begin
			value = $urandom;
		end

		send_request(kind, pos, value);

		held = list_model.entries.size();
		if (held == CAPACITY) begin
			filling = 1'b0;
		end else if (held == 0) begin
			filling = 1'b1;
		end else if ($urandom_range(99) < 3) begin
			filling = ~filling;
		end
	endtask

	// Overall time limit.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("array_list_engine_tb: done, errors");
		$finish;
	end

	// Reset, directed requests, random phases, drain and verdict.
	initial begin
		int send_pct [4];
		int recv_pct [4];
		send_pct = '{0, 71, 0, 36};
		recv_pct = '{0, 0, 71, 36};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = KIND_SEARCH;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Requests against the empty list, and kinds the block does not define.
		send_request(KIND_SEARCH, 5'd0, 32'h0000_0000);
		send_request(KIND_DELETE_AT, 5'd0, 32'h0000_0000);
		send_request(KIND_DELETE_VALUE, 5'd0, 32'hFFFF_FFFF);
		send_request(KIND_UNUSED_FIRST, 5'd31, 32'h1234_5678);
		send_request(KIND_UNUSED_LAST, 5'd16, 32'hFFFF_FFFF);

		// Fill to capacity with appends and inserts at the front and the middle;
		// zero goes in twice so a search must pick the first copy.
		for (int i = 0; i < CAPACITY; i++) begin
			logic [VALUE_W-1:0] v;
			v = (i < 4) ? value_pool[i] : ((i == 9) ? 32'h0000_0000 : $urandom);
			if (i % 4 == 1) begin
				send_request(KIND_INSERT, 5'd0, v);
			end else if (i % 4 == 3) begin
				send_request(KIND_INSERT, POS_W'(i / 2), v);
			end else begin
				send_request(KIND_APPEND, 5'd0, v);
			end
		end

		// Full list, hits and misses, bad positions.
		send_request(KIND_APPEND, 5'd0, 32'h7FFF_FFFF);
		send_request(KIND_INSERT, 5'd0, 32'h8000_0000);
		send_request(KIND_SEARCH, 5'd0, 32'h0000_0000);
		send_request(KIND_SEARCH, 5'd0, 32'h5A5A_5A5A);
		send_request(KIND_DELETE_VALUE, 5'd0, 32'h8000_0000);
		send_request(KIND_DELETE_VALUE, 5'd0, 32'h5A5A_5A5A);
		send_request(KIND_DELETE_AT, 5'd31, 32'h0000_0000);
		send_request(KIND_DELETE_AT, 5'd0, 32'h0000_0000);
		send_request(KIND_INSERT, 5'd16, 32'h0000_0001);

		// Random phases under different idle patterns.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 0 && n == HOLD_AT_ITEM) begin
					hold_request = 1'b1;
				end
				send_random_request();
			end
		end
		s_axis_tvalid <= 1'b0;

		// Let every owed result come back, then a few more cycles for strays.
		while (list_model.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (list_model.mismatches == 0 && list_model.pending() == 0) begin
			$display("array_list_engine_tb: done, clean");
		end else begin
			$display("array_list_engine_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/alc_pkg.sv
rtl/alc_cell.sv
rtl/array_list_engine.sv
verif/array_list_engine_tb.sv
